[rtl/png_chunk_framer_crc32_macros.svh]
// Assertion macros shared by the checker of the PNG chunk framer.
// No dependencies; include by bare file name.
`ifndef PNG_CHUNK_FRAMER_CRC32_MACROS_SVH
`define PNG_CHUNK_FRAMER_CRC32_MACROS_SVH

// General property, sampled on the rising clock and disabled in reset.
`define PCF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Antecedent in one cycle implies the consequent in the next cycle.
`define PCF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

[rtl/pcf_pkg.sv]
// Shared types, codes and the CRC-32 byte fold for the PNG chunk framer.
// No dependencies.
package pcf_pkg;

  localparam logic       KIND_BEGIN = 1'b0;
  localparam logic       KIND_DATA  = 1'b1;

  localparam logic [31:0] CRC_POLY  = 32'hedb88320;
  localparam logic [31:0] CRC_ONES  = 32'hffffffff;

  localparam int LEN_W      = 31;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int PHASE_W    = 4;

  typedef enum logic {
    CMD_HDR,
    CMD_DATA
  } cmd_kind_e;

  // One queued command. Close marks a command that also ends the chunk.
  typedef struct packed {
    cmd_kind_e        kind;
    logic             close;
    logic [LEN_W-1:0] len;
    logic [31:0]      ctype;
    logic [7:0]       data;
  } cmd_t;

  function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/pcf_if.sv]
// Valid/ready channel interfaces for the PNG chunk framer.
// Depends on pcf_pkg.
interface pcf_in_if import pcf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [LEN_W-1:0] chunk_length;
  logic [31:0]      chunk_type;
  logic [7:0]       data_byte;

  modport source (output valid, kind, chunk_length, chunk_type, data_byte, input ready);
  modport sink   (input valid, kind, chunk_length, chunk_type, data_byte, output ready);
endinterface

interface pcf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_chunk;

  modport source (output valid, out_byte, end_of_chunk, input ready);
  modport sink   (input valid, out_byte, end_of_chunk, output ready);
endinterface

[rtl/pcf_front.sv]
// Front end: accepts input items, tracks the open chunk and queues commands.
// Depends on pcf_pkg and pcf_in_if.
module pcf_front import pcf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  pcf_in_if.sink in_i,
  input  logic   q_full_i,
  output logic   push_o,
  output cmd_t   cmd_o
);

  logic             in_chunk_q, in_chunk_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic             acc;

  assign in_i.ready = !q_full_i;
  assign acc        = in_i.valid && in_i.ready;

  always_comb begin
    in_chunk_d  = in_chunk_q;
    rem_d       = rem_q;
    push_o      = 1'b0;
    cmd_o.len   = in_i.chunk_length;
    cmd_o.ctype = in_i.chunk_type;
    cmd_o.data  = in_i.data_byte;
    if (in_i.kind == KIND_BEGIN) begin
      cmd_o.kind  = CMD_HDR;
      cmd_o.close = (in_i.chunk_length == '0);
    end else begin
      cmd_o.kind  = CMD_DATA;
      cmd_o.close = (rem_q == LEN_W'(1));
    end
    if (acc) begin
      if (in_i.kind == KIND_BEGIN) begin
        // A begin item abandons any open chunk.
        push_o     = 1'b1;
        rem_d      = in_i.chunk_length;
        in_chunk_d = (in_i.chunk_length != '0);
      end else if (in_chunk_q) begin
        push_o     = 1'b1;
        rem_d      = rem_q - LEN_W'(1);
        in_chunk_d = (rem_q != LEN_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_chunk_q <= 1'b0;
      rem_q      <= '0;
    end else begin
      in_chunk_q <= in_chunk_d;
      rem_q      <= rem_d;
    end
  end

endmodule

[rtl/pcf_fifo.sv]
// Short command queue between the front and back ends.
// Depends on pcf_pkg.
module pcf_fifo import pcf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, rptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_q + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_q + FIFO_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + FIFO_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - FIFO_CNT_W'(1);
      end
    end
  end

endmodule

[rtl/pcf_back.sv]
// Back end: sequences queued commands into output bytes and runs the CRC.
// Depends on pcf_pkg and pcf_out_if.
module pcf_back import pcf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  cmd_t      cmd_i,
  output logic      pop_o,
  pcf_out_if.source out_o
);

  logic               busy_q, busy_d;
  cmd_t               cmd_q, cmd_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [31:0]        crc_q, crc_d;
  logic               ov_q, ov_d;
  logic [7:0]         ob_q, ob_d;
  logic               oe_q, oe_d;

  cmd_t               cur;
  logic               have, advance, last_phase, in_trailer;
  logic [PHASE_W-1:0] last_idx;
  logic [1:0]         sel;
  logic [31:0]        crc_out, len_word;
  logic [7:0]         byte_v;

  assign cur      = busy_q ? cmd_q : cmd_i;
  assign have     = busy_q || q_valid_i;
  assign advance  = !ov_q || out_o.ready;
  assign crc_out  = ~crc_q;
  assign len_word = {1'b0, cur.len};

  // Header phases: 0-3 length, 4-7 type, 8-11 CRC. Data phases: 0 byte, 1-4 CRC.
  always_comb begin
    if (cur.kind == CMD_HDR) begin
      last_idx   = cur.close ? PHASE_W'(11) : PHASE_W'(7);
      in_trailer = phase_q[3];
      sel        = phase_q[1:0];
    end else begin
      last_idx   = cur.close ? PHASE_W'(4) : PHASE_W'(0);
      in_trailer = (phase_q != '0);
      sel        = 2'(phase_q - PHASE_W'(1));
    end
    last_phase = (phase_q == last_idx);

    if (in_trailer) begin
      byte_v = crc_out[8*(3-sel) +: 8];
    end else if (cur.kind == CMD_DATA) begin
      byte_v = cur.data;
    end else if (!phase_q[2]) begin
      byte_v = len_word[8*(3-sel) +: 8];
    end else begin
      byte_v = cur.ctype[8*(3-sel) +: 8];
    end
  end

  always_comb begin
    busy_d  = busy_q;
    cmd_d   = cmd_q;
    phase_d = phase_q;
    crc_d   = crc_q;
    ov_d    = ov_q;
    ob_d    = ob_q;
    oe_d    = oe_q;
    pop_o   = 1'b0;
    if (advance) begin
      ov_d = 1'b0;
      if (have) begin
        ov_d = 1'b1;
        ob_d = byte_v;
        oe_d = in_trailer && last_phase;
        if (in_trailer) begin
          if (last_phase) begin
            crc_d = CRC_ONES;
          end
        end else if (cur.kind == CMD_DATA) begin
          crc_d = crc_fold(crc_q, byte_v);
        end else if (phase_q == PHASE_W'(4)) begin
          // The first type byte restarts the CRC.
          crc_d = crc_fold(CRC_ONES, byte_v);
        end else if (phase_q[2]) begin
          crc_d = crc_fold(crc_q, byte_v);
        end
        pop_o = !busy_q;
        if (last_phase) begin
          busy_d  = 1'b0;
          phase_d = '0;
        end else begin
          busy_d  = 1'b1;
          cmd_d   = cur;
          phase_d = phase_q + PHASE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= '0;
      crc_q   <= CRC_ONES;
      ov_q    <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      crc_q   <= crc_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    ob_q  <= ob_d;
    oe_q  <= oe_d;
  end

  assign out_o.valid        = ov_q;
  assign out_o.out_byte     = ob_q;
  assign out_o.end_of_chunk = oe_q;

endmodule

[rtl/png_chunk_framer_crc32.sv]
// PNG chunk framer with CRC-32: emits length, type, data and CRC as a byte stream.
// Input items are taken one per cycle whenever the two-entry command queue has room;
// the output delivers one byte per cycle while the sink is ready. A begin item gives
// the length and type bytes (plus the CRC trailer if zero-length), a data byte
// itself (the last also the CRC trailer), so the output sets the rate. Data bytes
// but the last go at one item per cycle while the sink is ready. Data outside a
// chunk is dropped. Depends on pcf_pkg, pcf_if, pcf_front, pcf_fifo and pcf_back.
module png_chunk_framer_crc32 import pcf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pcf_in_if.sink    in_i,
  pcf_out_if.source out_o
);

  logic push, full, pop, q_valid;
  cmd_t push_cmd, head_cmd;

  pcf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  pcf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  pcf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .cmd_i     (head_cmd),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

[rtl/pcf_checker.sv]
// Port-level checker for the PNG chunk framer, bound to the top level.
// Depends on pcf_pkg and png_chunk_framer_crc32_macros.svh.
`include "png_chunk_framer_crc32_macros.svh"

module pcf_checker import pcf_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_kind_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_end_i
);

  `PCF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `PCF_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_byte_i) && $stable(out_end_i))

  // The CRC trailer is four bytes, so two chunk ends never follow each other.
  `PCF_ASSERT_NEXT(a_end_spacing, clk_i, rst_ni, out_valid_i && out_ready_i && out_end_i, !(out_valid_i && out_end_i))

  // A begin item always produces output via the queue and output registers.
  `PCF_ASSERT(a_begin_out, clk_i, rst_ni, (in_valid_i && in_ready_i && in_kind_i == KIND_BEGIN) |-> ##2 out_valid_i)

endmodule

bind png_chunk_framer_crc32 pcf_checker u_pcf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_kind_i   (in_i.kind),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_end_i   (out_o.end_of_chunk)
);
